// ===== rtl/core/chacha_pkg.sv =====
// Shared types and constants for the ChaCha20 byte-stream cipher.
package chacha_pkg;

  typedef logic [31:0] word_t;

  // "expand 32-byte k"
  localparam word_t SIGMA_0 = 32'h6170_7865;
  localparam word_t SIGMA_1 = 32'h3320_646e;
  localparam word_t SIGMA_2 = 32'h7962_2d32;
  localparam word_t SIGMA_3 = 32'h6b20_6574;

  // Rotation amounts of the four quarter-round steps.
  localparam int ROT_1 = 16;
  localparam int ROT_2 = 12;
  localparam int ROT_3 = 8;
  localparam int ROT_4 = 7;

  localparam int DOUBLE_ROUNDS = 10;
  localparam int QR_PER_DOUBLE = 8;
  localparam int QR_STEPS      = DOUBLE_ROUNDS * QR_PER_DOUBLE;

  // Configuration register indexes.
  localparam logic [2:0] REG_KEY_A      = 3'd0;
  localparam logic [2:0] REG_KEY_B      = 3'd1;
  localparam logic [2:0] REG_KEY_C      = 3'd2;
  localparam logic [2:0] REG_KEY_D      = 3'd3;
  localparam logic [2:0] REG_NONCE_LOW  = 3'd4;
  localparam logic [2:0] REG_NONCE_HIGH = 3'd5;
  localparam logic [2:0] REG_INIT_CTR   = 3'd6;

endpackage

// ===== rtl/core/chacha_qr.sv =====
// One ChaCha quarter round on four 32-bit words.
module chacha_qr import chacha_pkg::*; (
  input  word_t a,
  input  word_t b,
  input  word_t c,
  input  word_t d,
  output word_t a_out,
  output word_t b_out,
  output word_t c_out,
  output word_t d_out
);

  word_t a1, b1, c1, d1, a2, b2, c2, d2;
  word_t dx1, bx1, dx2, bx2;

  always_comb begin
    a1  = a + b;
    dx1 = d ^ a1;
    d1  = (dx1 << ROT_1) | (dx1 >> (32 - ROT_1));
    c1  = c + d1;
    bx1 = b ^ c1;
    b1  = (bx1 << ROT_2) | (bx1 >> (32 - ROT_2));
    a2  = a1 + b1;
    dx2 = d1 ^ a2;
    d2  = (dx2 << ROT_3) | (dx2 >> (32 - ROT_3));
    c2  = c1 + d2;
    bx2 = b1 ^ c2;
    b2  = (bx2 << ROT_4) | (bx2 >> (32 - ROT_4));
  end

  assign a_out = a2;
  assign b_out = b2;
  assign c_out = c2;
  assign d_out = d2;

endmodule

// ===== rtl/core/chacha_core.sv =====
// Keystream block generator: one shared quarter-round unit under a step sequencer.
module chacha_core import chacha_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [255:0] key,
  input  logic [95:0]  nonce,
  input  word_t        counter,
  output logic         done,
  input  logic [3:0]   rd_addr,
  output word_t        rd_word
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_ROUND = 2'd1;
  localparam logic [1:0] S_ADD   = 2'd2;
  localparam logic [6:0] LAST_STEP = 7'(QR_STEPS - 1);

  logic [1:0] state;
  logic [6:0] step;
  word_t      counter_q;
  word_t      w [16];
  word_t      init_w [16];
  word_t      qr_w [16];
  word_t      perm_w [16];
  word_t      ctr_sel;
  logic [1:0] sh [4];
  word_t      qr_a, qr_b, qr_c, qr_d;

  // The quarter round always works on column 0; rows are rotated between
  // steps so that every column and then every diagonal passes through it.
  chacha_qr u_qr (
    .a(w[0]), .b(w[4]), .c(w[8]), .d(w[12]),
    .a_out(qr_a), .b_out(qr_b), .c_out(qr_c), .d_out(qr_d)
  );

  always_comb begin
    ctr_sel = (state == S_IDLE) ? counter : counter_q;
    init_w[0]  = SIGMA_0;
    init_w[1]  = SIGMA_1;
    init_w[2]  = SIGMA_2;
    init_w[3]  = SIGMA_3;
    for (int i = 0; i < 8; i++) begin
      init_w[4 + i] = key[32*i +: 32];
    end
    init_w[12] = ctr_sel;
    init_w[13] = nonce[31:0];
    init_w[14] = nonce[63:32];
    init_w[15] = nonce[95:64];
  end

  always_comb begin
    qr_w     = w;
    qr_w[0]  = qr_a;
    qr_w[4]  = qr_b;
    qr_w[8]  = qr_c;
    qr_w[12] = qr_d;
  end

  // Row shifts: skew into diagonal layout after the last column step, and
  // undo the skew after the last diagonal step.
  always_comb begin
    for (int r = 0; r < 4; r++) begin
      if (step[2:0] == 3'd3) begin
        sh[r] = 2'(1 + r);
      end else if (step[2:0] == 3'd7) begin
        sh[r] = 2'(1 - r);
      end else begin
        sh[r] = 2'd1;
      end
    end
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        perm_w[4*r + c] = qr_w[{2'(r), 2'(2'(c) + sh[r])}];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      step  <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (start) begin
            state <= S_ROUND;
            step  <= '0;
          end
        end
        S_ROUND: begin
          step <= step + 7'd1;
          if (step == LAST_STEP) begin
            state <= S_ADD;
          end
        end
        S_ADD: begin
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && start) begin
      counter_q <= counter;
      w         <= init_w;
    end else if (state == S_ROUND) begin
      w <= perm_w;
    end else if (state == S_ADD) begin
      for (int i = 0; i < 16; i++) begin
        w[i] <= w[i] + init_w[i];
      end
    end
  end

  assign done    = (state == S_ADD);
  assign rd_word = w[rd_addr];

endmodule

// ===== rtl/core/chacha20_stream_cipher_top.sv =====
// Top level of the ChaCha20 byte-stream cipher with its configuration registers.
//
// ChaCha20 (RFC 8439) encryption and decryption, one byte per transfer: each
// input byte is XORed with the next keystream byte and returned with its
// last flag. Key, nonce and initial block counter are written through the
// configuration port (index 0..3 key words, 4 and 5 nonce, 6 initial
// counter; other indexes are ignored); the user must write them only while
// no byte is in flight, as the block itself does not enforce this. A byte at
// keystream position 0 of a 64-byte block starts block generation: the
// shared quarter-round unit runs the 80 quarter rounds, one per cycle, then
// adds the initial state; the byte's result is then loaded into the result
// register, and no further byte is taken until that is done. The other 63
// bytes of a block use the stored keystream block. A result register sits
// on the output, so a new byte is taken while the previous result is still
// being delivered. After a byte flagged last, the next byte restarts at
// position 0 with the initial counter; the block counter wraps at 2^32.
module chacha20_stream_cipher_top import chacha_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        last_of_message,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte,
  output logic        out_last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_GEN  = 2'd1;
  localparam logic [1:0] S_EMIT = 2'd2;

  logic [1:0]  state;
  logic [63:0] key_a, key_b, key_c, key_d, nonce_low;
  logic [31:0] nonce_high, initial_counter;
  word_t       block_counter;
  logic [5:0]  byte_pos;
  logic        fresh;
  logic [7:0]  held_byte;
  logic        held_last;

  logic        in_xfer, out_free, new_block, out_load;
  word_t       ctr_use;
  logic [5:0]  pos_use;
  logic [5:0]  sel_pos;
  logic        core_done;
  word_t       ks_word;
  logic [7:0]  ks_byte;

  assign cfg_ready = 1'b1;

  // The output register can take a new value when empty or being drained.
  assign out_free  = !out_valid || !out_stall;
  assign in_stall  = (state != S_IDLE) || !out_free;
  assign in_xfer   = in_valid && !in_stall;
  assign ctr_use   = fresh ? initial_counter : block_counter;
  assign pos_use   = fresh ? 6'd0 : byte_pos;
  assign new_block = (pos_use == 6'd0);

  // A result is loaded either straight from a transfer that needs no new
  // block, or once the pending block has been generated.
  assign out_load  = (in_xfer && !new_block) || (state == S_EMIT && out_free);

  // While a new block is pending its first byte uses position 0.
  assign sel_pos = (state == S_IDLE) ? pos_use : 6'd0;

  chacha_core u_core (
    .clk     (clk),
    .rst     (rst),
    .start   (in_xfer && new_block),
    .key     ({key_d, key_c, key_b, key_a}),
    .nonce   ({nonce_high, nonce_low}),
    .counter (ctr_use),
    .done    (core_done),
    .rd_addr (sel_pos[5:2]),
    .rd_word (ks_word)
  );

  always_comb begin
    case (sel_pos[1:0])
      2'd0:    ks_byte = ks_word[7:0];
      2'd1:    ks_byte = ks_word[15:8];
      2'd2:    ks_byte = ks_word[23:16];
      default: ks_byte = ks_word[31:24];
    endcase
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      key_a           <= '0;
      key_b           <= '0;
      key_c           <= '0;
      key_d           <= '0;
      nonce_low       <= '0;
      nonce_high      <= '0;
      initial_counter <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_KEY_A:      key_a           <= cfg_data;
        REG_KEY_B:      key_b           <= cfg_data;
        REG_KEY_C:      key_c           <= cfg_data;
        REG_KEY_D:      key_d           <= cfg_data;
        REG_NONCE_LOW:  nonce_low       <= cfg_data;
        REG_NONCE_HIGH: nonce_high      <= cfg_data[31:0];
        REG_INIT_CTR:   initial_counter <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  // Stream control and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      block_counter <= '0;
      byte_pos      <= '0;
      fresh         <= 1'b1;
      out_valid     <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_xfer) begin
            byte_pos <= pos_use + 6'd1;
            fresh    <= last_of_message;
            if (new_block) begin
              block_counter <= ctr_use + 32'd1;
              state         <= S_GEN;
            end
          end
        end
        S_GEN: begin
          if (core_done) begin
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_xfer) begin
      held_byte <= data_byte;
      held_last <= last_of_message;
      if (!new_block) begin
        out_byte <= data_byte ^ ks_byte;
        out_last <= last_of_message;
      end
    end else if (state == S_EMIT && out_free) begin
      out_byte <= held_byte ^ ks_byte;
      out_last <= held_last;
    end
  end

endmodule

// ===== verif/tb.sv =====
// Self-checking testbench for the ChaCha20 byte-stream cipher top level.
`timescale 1ns / 1ps

module tb;
  import chacha_pkg::*;

  // Index 7 is not mapped to any register, so a write to it must be ignored.
  localparam logic [2:0] REG_UNUSED = 3'd7;

  // The "expand 32-byte k" words are kept here on purpose so that a typo in
  // the RTL package shows up as a keystream mismatch.
  localparam word_t EXPAND_0 = 32'h6170_7865;
  localparam word_t EXPAND_1 = 32'h3320_646e;
  localparam word_t EXPAND_2 = 32'h7962_2d32;
  localparam word_t EXPAND_3 = 32'h6b20_6574;

  localparam int DIR_ROWS     = 18;
  localparam int DIR_MAX_AT   = 5;    // first directed row under all-ones settings
  localparam int DIR_RFC_AT   = 11;   // first directed row under the RFC 8439 key
  localparam int RAND_PHASES  = 6;
  localparam int PHASE_BYTES  = 300;
  localparam int HOLD_CYCLES  = 400;
  localparam int PRINT_LIMIT  = 100;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } cipher_byte_t;

  // The upper halves of nonce_hi and ctr_init are written as well; the block
  // must drop them.
  typedef struct packed {
    logic [3:0][63:0] key;
    logic [63:0]      nonce_lo;
    logic [63:0]      nonce_hi;
    logic [63:0]      ctr_init;
  } cipher_settings_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  data_byte = 8'h00;
  logic        last_of_message = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  out_byte;
  logic        out_last;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = REG_KEY_A;
  logic [63:0] cfg_data = 64'h0;

  chacha20_stream_cipher_top dut (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .data_byte       (data_byte),
    .last_of_message (last_of_message),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_byte        (out_byte),
    .out_last        (out_last),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  always #10 clk = ~clk;

  // Idle rates in percent; the main sequence changes them between phases.
  int unsigned gap_pct   = 19;
  int unsigned stall_pct = 65;

  // The main sequence raises want_hold; the output side then keeps out_stall
  // high until hold_left counts down from HOLD_CYCLES, while bytes keep arriving.
  logic        want_hold = 1'b0;
  int unsigned hold_left = 0;

  int unsigned bytes_sent     = 0;
  int unsigned bytes_returned = 0;
  int unsigned cipher_errors  = 0;

  // Shadow of the block: configuration registers and keystream state.
  logic [63:0] key_reg [4];
  logic [63:0] nonce_lo_reg;
  word_t       nonce_hi_reg;
  word_t       ctr_init_reg;
  word_t       ks_words [16];
  word_t       blk_ctr;
  logic [5:0]  byte_pos;
  logic        msg_fresh;

  cipher_byte_t expected_out [$];
  cipher_byte_t oldest_out;
  cipher_byte_t directed_rows [DIR_ROWS];

  task automatic report_mismatch(input string msg);
    if (cipher_errors < PRINT_LIMIT)
      $display("mismatch at %0t ns: %s", $time, msg);
    cipher_errors++;
  endtask

  function automatic word_t rotl(input word_t x, input int n);
    return (x << n) | (x >> (32 - n));
  endfunction

  // Works out the result of one byte transfer and advances the shadow state.
  // A fresh message reloads the counter from ctr_init; position 0 of a block
  // runs the full 20-round core on the key and nonce that are current now.
  function automatic cipher_byte_t encipher_byte(input logic [7:0] d, input logic l);
    word_t        init_w [16];
    word_t        w [16];
    word_t        ks_word;
    int           i, j, q, dg, ia, ib, ic, id;
    cipher_byte_t r;
    if (msg_fresh) begin
      blk_ctr   = ctr_init_reg;
      byte_pos  = 6'd0;
      msg_fresh = 1'b0;
    end
    if (byte_pos == 6'd0) begin
      init_w[0] = EXPAND_0;
      init_w[1] = EXPAND_1;
      init_w[2] = EXPAND_2;
      init_w[3] = EXPAND_3;
      for (i = 0; i < 8; i++)
        init_w[4 + i] = key_reg[i / 2][32 * (i % 2) +: 32];
      init_w[12] = blk_ctr;
      init_w[13] = nonce_lo_reg[31:0];
      init_w[14] = nonce_lo_reg[63:32];
      init_w[15] = nonce_hi_reg;
      w = init_w;
      // Quarter rounds 0..3 of a double round work on columns, 4..7 on
      // diagonals; the diagonal offsets follow from rotating each row.
      for (i = 0; i < 10; i++) begin
        for (j = 0; j < 8; j++) begin
          q  = j % 4;
          dg = j / 4;
          ia = q;
          ib = 4 + (q + dg) % 4;
          ic = 8 + (q + 2 * dg) % 4;
          id = 12 + (q + 3 * dg) % 4;
          w[ia] = w[ia] + w[ib]; w[id] = rotl(w[id] ^ w[ia], 16);
          w[ic] = w[ic] + w[id]; w[ib] = rotl(w[ib] ^ w[ic], 12);
          w[ia] = w[ia] + w[ib]; w[id] = rotl(w[id] ^ w[ia], 8);
          w[ic] = w[ic] + w[id]; w[ib] = rotl(w[ib] ^ w[ic], 7);
        end
      end
      for (i = 0; i < 16; i++)
        ks_words[i] = w[i] + init_w[i];
      blk_ctr = blk_ctr + 32'd1;
    end
    ks_word = ks_words[byte_pos[5:2]];
    r.data  = d ^ ks_word[8 * byte_pos[1:0] +: 8];
    r.last  = l;
    byte_pos = byte_pos + 6'd1;
    if (l)
      msg_fresh = 1'b1;
    return r;
  endfunction

  // Scoreboard. The result side is handled before the input side, so a byte
  // that came straight through in the cycle it was taken counts as unexpected.
  always @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < 4; k++)
        key_reg[k] = 64'h0;
      nonce_lo_reg = 64'h0;
      nonce_hi_reg = 32'h0;
      ctr_init_reg = 32'h0;
      blk_ctr      = 32'h0;
      byte_pos     = 6'd0;
      msg_fresh    = 1'b1;
      expected_out.delete();
    end else begin
      if (out_valid && !out_stall) begin
        bytes_returned++;
        if (expected_out.size() == 0) begin
          report_mismatch($sformatf("byte %02h last %0b with nothing expected",
                                    out_byte, out_last));
        end else begin
          oldest_out = expected_out.pop_front();
          if (out_byte !== oldest_out.data)
            report_mismatch($sformatf("out_byte %02h, expected %02h",
                                      out_byte, oldest_out.data));
          if (out_last !== oldest_out.last)
            report_mismatch($sformatf("out_last %0b, expected %0b",
                                      out_last, oldest_out.last));
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_KEY_A:      key_reg[0]   = cfg_data;
          REG_KEY_B:      key_reg[1]   = cfg_data;
          REG_KEY_C:      key_reg[2]   = cfg_data;
          REG_KEY_D:      key_reg[3]   = cfg_data;
          REG_NONCE_LOW:  nonce_lo_reg = cfg_data;
          REG_NONCE_HIGH: nonce_hi_reg = cfg_data[31:0];
          REG_INIT_CTR:   ctr_init_reg = cfg_data[31:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall)
        expected_out.push_back(encipher_byte(data_byte, last_of_message));
    end
  end

  // Output side: random stalls, or a long hold when the main sequence asks.
  always @(posedge clk) begin
    if (want_hold) begin
      want_hold = 1'b0;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // Offers one byte, after a random gap, and returns at the edge of its
  // transfer. The payload holds still while the block stalls.
  task automatic send_byte(input logic [7:0] d, input logic l);
    if ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      do
        @(posedge clk);
      while ($urandom_range(99) < gap_pct);
    end
    in_valid        <= 1'b1;
    data_byte       <= d;
    last_of_message <= l;
    @(posedge clk);
    while (in_stall)
      @(posedge clk);
    bytes_sent++;
  endtask

  // Drops the input valid and waits until every byte sent has come back.
  task automatic wait_for_results();
    in_valid <= 1'b0;
    while (bytes_returned != bytes_sent)
      @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready)
      @(posedge clk);
  endtask

  // Writes every register, plus a junk write to the unmapped index.
  task automatic load_settings(input cipher_settings_t s);
    write_reg(REG_KEY_A, s.key[0]);
    write_reg(REG_KEY_B, s.key[1]);
    write_reg(REG_KEY_C, s.key[2]);
    write_reg(REG_KEY_D, s.key[3]);
    write_reg(REG_NONCE_LOW, s.nonce_lo);
    write_reg(REG_NONCE_HIGH, s.nonce_hi);
    write_reg(REG_INIT_CTR, s.ctr_init);
    write_reg(REG_UNUSED, {$urandom, $urandom});
    cfg_valid <= 1'b0;
  endtask

  // Sends well-formed messages of random content. Most are short or span a
  // block boundary; a few stray last flags split messages early. The final
  // message may be cut off at the phase end, so the next settings can arrive
  // in the middle of a message.
  task automatic run_messages(input int unsigned n_bytes);
    int unsigned left, len, k, r;
    left = n_bytes;
    while (left > 0) begin
      r = $urandom_range(99);
      if (r < 40)
        len = $urandom_range(8, 1);
      else if (r < 80)
        len = $urandom_range(70, 9);
      else
        len = $urandom_range(140, 60);
      for (k = 0; k < len && left > 0; k++) begin
        send_byte($urandom_range(255), (k == len - 1) || ($urandom_range(49) == 0));
        left--;
      end
    end
  endtask

  // Run limit: 20 ms, several times the slowest correct run even if every
  // byte had to wait for a fresh block.
  initial begin
    #(20_000_000);
    $display("[chacha20_stream_cipher_top] ERROR");
    $finish;
  end

  initial begin
    cipher_settings_t s;
    int i, p;

    // Directed bytes. The first rows run on the reset settings (all zero
    // key and nonce, counter 0): a three-byte message followed by two
    // single-byte messages. Then all-ones settings, where the counter
    // starts at its top value, and last the RFC 8439 sample key with the
    // start of its sample plaintext and a one-byte message that restarts
    // the counter.
    directed_rows = '{
      '{8'h00, 1'b0}, '{8'hff, 1'b0}, '{8'h5a, 1'b1}, '{8'hff, 1'b1}, '{8'h00, 1'b1},
      '{8'h00, 1'b0}, '{8'hff, 1'b0}, '{8'h01, 1'b0}, '{8'h80, 1'b0}, '{8'h7f, 1'b0},
      '{8'hfe, 1'b1},
      '{8'h4c, 1'b0}, '{8'h61, 1'b0}, '{8'h64, 1'b0}, '{8'h69, 1'b0}, '{8'h65, 1'b0},
      '{8'h73, 1'b1}, '{8'hff, 1'b1}
    };

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    for (i = 0; i < DIR_ROWS; i++) begin
      if (i == DIR_MAX_AT) begin
        wait_for_results();
        s.key      = {4{64'hffff_ffff_ffff_ffff}};
        s.nonce_lo = 64'hffff_ffff_ffff_ffff;
        s.nonce_hi = 64'hffff_ffff_ffff_ffff;
        s.ctr_init = 64'hffff_ffff_ffff_ffff;
        load_settings(s);
      end
      if (i == DIR_RFC_AT) begin
        wait_for_results();
        s.key[0]   = 64'h0706_0504_0302_0100;
        s.key[1]   = 64'h0f0e_0d0c_0b0a_0908;
        s.key[2]   = 64'h1716_1514_1312_1110;
        s.key[3]   = 64'h1f1e_1d1c_1b1a_1918;
        s.nonce_lo = 64'h4a00_0000_0000_0000;
        s.nonce_hi = 64'h0;
        s.ctr_init = 64'h1;
        load_settings(s);
      end
      send_byte(directed_rows[i].data, directed_rows[i].last);
    end
    wait_for_results();

    // Random phases. Phases 0 and 1 idle the sender lightly and the receiver
    // heavily, 2 and 3 the other way round, 4 and 5 not at all. The counter
    // start sits at or near its top in some phases so that long messages
    // wrap it; phase 4 also holds the output off long enough to back the
    // block up.
    for (p = 0; p < RAND_PHASES; p++) begin
      gap_pct   = (p < 2) ? 19 : (p < 4) ? 65 : 0;
      stall_pct = (p < 2) ? 65 : (p < 4) ? 19 : 0;
      s.key      = {$urandom, $urandom, $urandom, $urandom,
                    $urandom, $urandom, $urandom, $urandom};
      s.nonce_lo = {$urandom, $urandom};
      s.nonce_hi = {$urandom, $urandom};
      s.ctr_init = {$urandom, $urandom};
      case (p)
        0: begin
          s.key          = '0;
          s.nonce_lo     = '0;
          s.nonce_hi[31:0] = 32'h0;
          s.ctr_init[31:0] = 32'h0;
        end
        1: s.ctr_init[31:0] = 32'hffff_ffff;
        2: begin
          s.key          = '1;
          s.nonce_lo     = '1;
          s.nonce_hi[31:0] = 32'hffff_ffff;
          s.ctr_init[31:0] = 32'hffff_ffff;
        end
        5: s.ctr_init[31:0] = 32'hffff_fffe;
        default: ;
      endcase
      load_settings(s);
      if (p == 4)
        want_hold = 1'b1;
      run_messages(PHASE_BYTES);
      wait_for_results();
    end

    // Leave room for any stray result after the last expected one.
    repeat (20) @(posedge clk);
    if (cipher_errors == 0)
      $display("[chacha20_stream_cipher_top] OK");
    else
      $display("[chacha20_stream_cipher_top] ERROR");
    $finish;
  end

endmodule
